// File: hw/rtl/lcdnib_pkg.sv
// lcdnib_pkg: shared types, codes and tables for the character lcd nibble sequencer
// used by lcdnib_csr, lcdnib_core and char_lcd_nibble_sequencer; no dependencies

package lcdnib_pkg;

   // default display width in characters
   localparam int DefColumns = 16;

   // csr address width: six 32-bit registers at byte offsets 0..20
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   // register indexes on the csr port
   localparam logic [2:0] RegPowerUpWait   = 3'd0;
   localparam logic [2:0] RegLongCmdWait   = 3'd1;
   localparam logic [2:0] RegEnablePulse   = 3'd2;
   localparam logic [2:0] RegNibbleGap     = 3'd3;
   localparam logic [2:0] RegCommandSettle = 3'd4;
   localparam logic [2:0] RegDataSettle    = 3'd5;

   // operation codes of a request transaction
   localparam logic [2:0] OpTick     = 3'd0;
   localparam logic [2:0] OpInit     = 3'd1;
   localparam logic [2:0] OpCommand  = 3'd2;
   localparam logic [2:0] OpData     = 3'd3;
   localparam logic [2:0] OpPosition = 3'd4;
   localparam logic [2:0] OpDeinit   = 3'd5;

   // error codes of a response transaction
   localparam logic [2:0] ErrNone       = 3'd0;
   localparam logic [2:0] ErrBusy       = 3'd1;
   localparam logic [2:0] ErrInitDone   = 3'd2;
   localparam logic [2:0] ErrNotInit    = 3'd3;
   localparam logic [2:0] ErrBadPos     = 3'd4;

   // row base addresses and nibble masks
   localparam logic [7:0] Row1Base = 8'h80;
   localparam logic [7:0] Row2Base = 8'hC0;
   localparam logic [7:0] HiMask   = 8'hF0;
   localparam logic [7:0] LoMask   = 8'h0F;

   // last init step (entry mode)
   localparam logic [2:0] LastInitStep = 3'd4;

   // request payload
   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] byte_value;
      logic [1:0] row;
      logic [4:0] column;
   } req_type;

   // response payload
   typedef struct packed {
      logic       register_select;
      logic       read_write;
      logic       enable;
      logic [3:0] data_nibble;
      logic       busy_res;
      logic       ready_res;
      logic       done_res;
      logic [2:0] error;
   } rsp_type;

   // timing configuration handed from csr block to core
   typedef struct packed {
      logic [7:0] power_up_wait_ticks;
      logic [7:0] long_command_wait_ticks;
      logic [7:0] enable_pulse_ticks;
      logic [7:0] nibble_gap_ticks;
      logic [7:0] command_settle_ticks;
      logic [7:0] data_settle_ticks;
   } cfg_type;

   // init command bytes: home, function set, display on, clear, entry mode
   function automatic logic [7:0] init_cmd(input logic [2:0] step);
      logic [7:0] cmd;
      case (step)
         3'd0:    cmd = 8'h02;
         3'd1:    cmd = 8'h28;
         3'd2:    cmd = 8'h0C;
         3'd3:    cmd = 8'h01;
         default: cmd = 8'h06;
      endcase
      return cmd;
   endfunction

endpackage

// File: hw/rtl/lcdnib_csr.sv
// lcdnib_csr: apb-style timing register file of the lcd nibble sequencer
// depends on lcdnib_pkg

module lcdnib_csr
   import lcdnib_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output cfg_type                 cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       write_en;
   logic [7:0] wdata;
   logic [7:0] rdata;

   assign reg_index = csr_paddr[4:2];
   assign write_en  = csr_psel && csr_penable && csr_pwrite;
   assign wdata     = csr_pwdata[7:0];

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            RegPowerUpWait:   cfg_in.power_up_wait_ticks     = wdata;
            RegLongCmdWait:   cfg_in.long_command_wait_ticks = wdata;
            RegEnablePulse:   cfg_in.enable_pulse_ticks      = wdata;
            RegNibbleGap:     cfg_in.nibble_gap_ticks        = wdata;
            RegCommandSettle: cfg_in.command_settle_ticks    = wdata;
            RegDataSettle:    cfg_in.data_settle_ticks       = wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_up_wait_ticks     <= 8'd30;
         cfg_ff.long_command_wait_ticks <= 8'd14;
         cfg_ff.enable_pulse_ticks      <= 8'd5;
         cfg_ff.nibble_gap_ticks        <= 8'd10;
         cfg_ff.command_settle_ticks    <= 8'd20;
         cfg_ff.data_settle_ticks       <= 8'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_index)
         RegPowerUpWait:   rdata = cfg_ff.power_up_wait_ticks;
         RegLongCmdWait:   rdata = cfg_ff.long_command_wait_ticks;
         RegEnablePulse:   rdata = cfg_ff.enable_pulse_ticks;
         RegNibbleGap:     rdata = cfg_ff.nibble_gap_ticks;
         RegCommandSettle: rdata = cfg_ff.command_settle_ticks;
         RegDataSettle:    rdata = cfg_ff.data_settle_ticks;
         default:          rdata = 8'd0;
      endcase
   end

   assign csr_prdata = {{(CsrDataWidth-8){1'b0}}, rdata};
   assign cfg        = cfg_ff;

endmodule

// File: hw/rtl/lcdnib_core.sv
// lcdnib_core: sequencer state and one-transaction next-state and pin logic
// depends on lcdnib_pkg

module lcdnib_core
   import lcdnib_pkg::*;
#(
   parameter int COLUMNS = DefColumns
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   typedef enum logic [2:0] {
      PhIdle,
      PhPower,
      PhHiE,
      PhGap,
      PhLoE,
      PhSettle,
      PhLong
   } phase_type;

   localparam logic [5:0] ColLimit = 6'(COLUMNS);

   phase_type  phase_ff,        phase_in;
   logic [7:0] tick_ff,         tick_in;
   logic [2:0] step_ff,         step_in;
   logic [7:0] held_byte_ff,    held_byte_in;
   logic       held_select_ff,  held_select_in;
   logic       init_running_ff, init_running_in;
   logic       initialized_ff,  initialized_in;

   logic       busy;
   logic [7:0] wait_len;
   logic [8:0] tick_plus;
   logic       wait_done;
   logic       done;
   logic [2:0] err;
   logic       pos_ok;
   logic [7:0] pos_byte;
   logic [2:0] next_step;

   assign busy = (phase_ff != PhIdle);

   // wait length of the current phase
   always_comb begin
      case (phase_ff)
         PhPower:  wait_len = cfg.power_up_wait_ticks;
         PhHiE:    wait_len = cfg.enable_pulse_ticks;
         PhGap:    wait_len = cfg.nibble_gap_ticks;
         PhLoE:    wait_len = cfg.enable_pulse_ticks;
         PhSettle: wait_len = held_select_ff ? cfg.data_settle_ticks
                                             : cfg.command_settle_ticks;
         PhLong:   wait_len = cfg.long_command_wait_ticks;
         default:  wait_len = 8'd0;
      endcase
   end

   // tick counter compare; a zero length ends after one tick like one
   assign tick_plus = {1'b0, tick_ff} + 9'd1;
   assign wait_done = (tick_plus >= {1'b0, wait_len});

   // position check and cursor address
   assign pos_ok   = ((req.row == 2'd1) || (req.row == 2'd2)) && (req.column != 5'd0)
                     && ({1'b0, req.column} <= ColLimit);
   assign pos_byte = ((req.row == 2'd1) ? Row1Base : Row2Base) + {3'b000, req.column}
                     - 8'd1;

   assign next_step = step_ff + 3'd1;

   // next state for one transaction
   always_comb begin
      phase_in        = phase_ff;
      tick_in         = tick_ff;
      step_in         = step_ff;
      held_byte_in    = held_byte_ff;
      held_select_in  = held_select_ff;
      init_running_in = init_running_ff;
      initialized_in  = initialized_ff;
      done            = 1'b0;
      err             = ErrNone;

      case (req.operation)
         OpTick: begin
            if (busy) begin
               tick_in = wait_done ? 8'd0 : tick_plus[7:0];
            end
            case (phase_ff)
               PhPower: begin
                  if (wait_done) begin
                     step_in        = 3'd0;
                     held_byte_in   = init_cmd(3'd0);
                     held_select_in = 1'b0;
                     phase_in       = PhHiE;
                  end
               end
               PhHiE: begin
                  if (wait_done) phase_in = PhGap;
               end
               PhGap: begin
                  if (wait_done) phase_in = PhLoE;
               end
               PhLoE: begin
                  if (wait_done) phase_in = PhSettle;
               end
               PhSettle: begin
                  if (wait_done) begin
                     if (!init_running_ff) begin
                        phase_in = PhIdle;
                        done     = 1'b1;
                     end else if ((step_ff == 3'd0) || (step_ff == 3'd3)) begin
                        phase_in = PhLong;
                     end else if (step_ff >= LastInitStep) begin
                        init_running_in = 1'b0;
                        initialized_in  = 1'b1;
                        phase_in        = PhIdle;
                        done            = 1'b1;
                     end else begin
                        step_in        = next_step;
                        held_byte_in   = init_cmd(next_step);
                        held_select_in = 1'b0;
                        phase_in       = PhHiE;
                     end
                  end
               end
               PhLong: begin
                  if (wait_done) begin
                     step_in        = next_step;
                     held_byte_in   = init_cmd(next_step);
                     held_select_in = 1'b0;
                     phase_in       = PhHiE;
                  end
               end
               default: phase_in = PhIdle;
            endcase
         end
         OpInit: begin
            if (busy) begin
               err = ErrBusy;
            end else if (initialized_ff) begin
               err = ErrInitDone;
            end else begin
               init_running_in = 1'b1;
               step_in         = 3'd0;
               held_byte_in    = 8'd0;
               held_select_in  = 1'b0;
               phase_in        = PhPower;
               tick_in         = 8'd0;
            end
         end
         OpCommand: begin
            if (busy) begin
               err = ErrBusy;
            end else begin
               held_byte_in   = req.byte_value;
               held_select_in = 1'b0;
               phase_in       = PhHiE;
               tick_in        = 8'd0;
            end
         end
         OpData: begin
            if (busy) begin
               err = ErrBusy;
            end else if (!initialized_ff) begin
               err = ErrNotInit;
            end else begin
               held_byte_in   = req.byte_value;
               held_select_in = 1'b1;
               phase_in       = PhHiE;
               tick_in        = 8'd0;
            end
         end
         OpPosition: begin
            if (busy) begin
               err = ErrBusy;
            end else if (!initialized_ff) begin
               err = ErrNotInit;
            end else if (!pos_ok) begin
               err = ErrBadPos;
            end else begin
               held_byte_in   = pos_byte;
               held_select_in = 1'b0;
               phase_in       = PhHiE;
               tick_in        = 8'd0;
            end
         end
         OpDeinit: begin
            if (busy) err = ErrBusy;
            else      initialized_in = 1'b0;
         end
         default: ;
      endcase
   end

   // pin levels after the transaction
   always_comb begin
      rsp.register_select = held_select_in;
      rsp.read_write      = 1'b0;
      rsp.enable          = (phase_in == PhHiE) || (phase_in == PhLoE);
      if ((phase_in == PhHiE) || (phase_in == PhGap)) begin
         rsp.data_nibble = held_byte_in[7:4] & HiMask[7:4];
      end else begin
         rsp.data_nibble = held_byte_in[3:0] & LoMask[3:0];
      end
      rsp.busy_res  = (phase_in != PhIdle);
      rsp.ready_res = initialized_in;
      rsp.done_res  = done;
      rsp.error     = err;
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PhIdle;
         tick_ff         <= 8'd0;
         step_ff         <= 3'd0;
         held_byte_ff    <= 8'd0;
         held_select_ff  <= 1'b0;
         init_running_ff <= 1'b0;
         initialized_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         tick_ff         <= tick_in;
         step_ff         <= step_in;
         held_byte_ff    <= held_byte_in;
         held_select_ff  <= held_select_in;
         init_running_ff <= init_running_in;
         initialized_ff  <= initialized_in;
      end
   end

endmodule

// File: hw/rtl/char_lcd_nibble_sequencer.sv
// char_lcd_nibble_sequencer: top level with request register, response register and csr port
// depends on lcdnib_pkg, lcdnib_csr and lcdnib_core

// Tick-driven sequencer for an HD44780-style character display on a 4-bit bus.
// Each request transaction (a tick, init, command, data, position or deinit) returns
// exactly one response transaction carrying the RS, RW, E and D7..D4 pin levels and
// busy, ready, done and error status as they stand after that transaction. The block
// takes one transaction per clock cycle while the response side does not stall; a
// transaction is captured in the request register and its response moves into the
// response register once that register is free. Rate is set by the single next-state
// step of the sequencer state between those two registers.
// Timing registers on the csr port are to be written only while the block is idle.

module char_lcd_nibble_sequencer
   import lcdnib_pkg::*;
#(
   parameter int COLUMNS = DefColumns
)
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   // csr port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   logic    req_valid_ff;
   req_type req_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    advance;
   logic    req_take;
   cfg_type cfg;
   rsp_type step_rsp;

   // move the held request into the response register when it is free
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // timing registers
   lcdnib_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   assign csr_pready = 1'b1;

   // sequencer state and step logic
   lcdnib_core #(
      .COLUMNS (COLUMNS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (req_data_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_data_ff <= req_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
